[hdl/ict_pkg.sv]
// ict_pkg: shared constants and types for the incircle test core
// no dependencies; compiled before the interfaces and all modules
`default_nettype none

package ict_pkg;

  // default coordinate width: signed Q8.16
  localparam int unsigned COORD_WIDTH_DEF = 24;

  // relation codes carried on the result channel
  typedef enum logic [1:0] {
    REL_INSIDE     = 2'd0,
    REL_OUTSIDE    = 2'd1,
    REL_ON         = 2'd2,
    REL_DEGENERATE = 2'd3
  } relation_e;

  // stage enables handed to the split multiplier
  typedef struct packed {
    logic pp;   // partial product stage
    logic sum;  // partial product recombination stage
  } ict_mul_en_t;

endpackage

`default_nettype wire

[hdl/ict_if.sv]
// ict_if: request and result channel interfaces of the incircle test core
// depends on ict_pkg for the default coordinate width
`default_nettype none

interface ict_in_if import ict_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic signed [COORD_WIDTH-1:0] vertex_a_x;
  logic signed [COORD_WIDTH-1:0] vertex_a_y;
  logic signed [COORD_WIDTH-1:0] vertex_b_x;
  logic signed [COORD_WIDTH-1:0] vertex_b_y;
  logic signed [COORD_WIDTH-1:0] vertex_c_x;
  logic signed [COORD_WIDTH-1:0] vertex_c_y;

  modport source (
    output valid, point_x, point_y, vertex_a_x, vertex_a_y,
           vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_a_x, vertex_a_y,
           vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    output ready
  );
endinterface

interface ict_out_if import ict_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] relation;

  modport source (output valid, relation, input ready);
  modport sink (input valid, relation, output ready);
endinterface

`default_nettype wire

[hdl/ict_term_mul.sv]
// ict_term_mul: two-stage signed multiplier, norm times cross term
// splits both operands in halves; depends on ict_pkg for the enable struct
`default_nettype none

module ict_term_mul import ict_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                                clk_i,
  input  wire ict_mul_en_t                         en_i,
  input  wire logic signed [2*(COORD_WIDTH+1):0]   norm_i,
  input  wire logic signed [2*(COORD_WIDTH+1):0]   cross_i,
  output logic signed [4*(COORD_WIDTH+1)+1:0]      term_o
);

  localparam int unsigned DiffW  = COORD_WIDTH + 1;
  localparam int unsigned NormW  = 2 * DiffW + 1;
  localparam int unsigned SplitW = (NormW + 1) / 2;
  localparam int unsigned HighW  = NormW - SplitW;
  localparam int unsigned TermW  = 2 * NormW;

  logic        [SplitW-1:0]       norm_lo, cross_lo;
  logic signed [HighW-1:0]        norm_hi, cross_hi;

  logic        [2*SplitW-1:0]     pp_ll_q;
  logic signed [SplitW+HighW:0]   pp_lh_q, pp_hl_q;
  logic signed [2*HighW-1:0]      pp_hh_q;
  logic signed [TermW-1:0]        term_d, term_q;

  assign norm_lo  = norm_i[SplitW-1:0];
  assign cross_lo = cross_i[SplitW-1:0];
  assign norm_hi  = norm_i[NormW-1:SplitW];
  assign cross_hi = cross_i[NormW-1:SplitW];

  // four partial products, each within one multiplier
  always_ff @(posedge clk_i) begin
    if (en_i.pp) begin
      pp_ll_q <= norm_lo * cross_lo;
      pp_lh_q <= $signed({1'b0, norm_lo}) * cross_hi;
      pp_hl_q <= norm_hi * $signed({1'b0, cross_lo});
      pp_hh_q <= norm_hi * cross_hi;
    end
  end

  assign term_d = (TermW'(pp_hh_q) << (2 * SplitW))
                + (TermW'(pp_lh_q) << SplitW)
                + (TermW'(pp_hl_q) << SplitW)
                + TermW'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i.sum) begin
      term_q <= term_d;
    end
  end

  assign term_o = term_q;

endmodule

`default_nettype wire

[hdl/incircle_test_core.sv]
// incircle_test_core: exact incircle predicate, seven-stage pipeline
// throughput: one request per cycle while rsp_o.ready holds; a stage loads when empty or when the next moves on
// reset: rst_ni clears the stage valid bits only; datapath registers hold
// depends on ict_pkg, ict_in_if, ict_out_if and ict_term_mul
`default_nettype none

module incircle_test_core import ict_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ict_in_if.sink     req_i,
  ict_out_if.source  rsp_o
);

  // widths grow as the arithmetic goes: difference, product, sum, big product
  localparam int unsigned DiffW     = COORD_WIDTH + 1;
  localparam int unsigned ProdW     = 2 * DiffW;
  localparam int unsigned NormW     = ProdW + 1;
  localparam int unsigned TermW     = 2 * NormW;
  localparam int unsigned DetW      = TermW + 2;
  localparam int unsigned NumStages = 7;

  // ---------------------------------------------------------------------
  // handshake: every stage holds a valid bit; a stage loads when it is
  // empty or when the stage after it moves on, so bubbles collapse and a
  // stalled result blocks requests only once every stage is full
  // ---------------------------------------------------------------------
  logic [NumStages:1]   v_q;
  logic [NumStages+1:1] en;
  logic [NumStages:1]   v_in;

  always_comb begin
    en[NumStages+1] = rsp_o.ready;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign v_in        = {v_q[NumStages-1:1], req_i.valid};
  assign req_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_in[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: vertex offsets from the query point, and triangle edges
  // ---------------------------------------------------------------------
  logic signed [DiffW-1:0] da_x_q, da_y_q, db_x_q, db_y_q, dc_x_q, dc_y_q;
  logic signed [DiffW-1:0] e1_x_q, e1_y_q, e2_x_q, e2_y_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      da_x_q <= DiffW'(req_i.vertex_a_x) - DiffW'(req_i.point_x);
      da_y_q <= DiffW'(req_i.vertex_a_y) - DiffW'(req_i.point_y);
      db_x_q <= DiffW'(req_i.vertex_b_x) - DiffW'(req_i.point_x);
      db_y_q <= DiffW'(req_i.vertex_b_y) - DiffW'(req_i.point_y);
      dc_x_q <= DiffW'(req_i.vertex_c_x) - DiffW'(req_i.point_x);
      dc_y_q <= DiffW'(req_i.vertex_c_y) - DiffW'(req_i.point_y);
      e1_x_q <= DiffW'(req_i.vertex_b_x) - DiffW'(req_i.vertex_a_x);
      e1_y_q <= DiffW'(req_i.vertex_b_y) - DiffW'(req_i.vertex_a_y);
      e2_x_q <= DiffW'(req_i.vertex_c_x) - DiffW'(req_i.vertex_a_x);
      e2_y_q <= DiffW'(req_i.vertex_c_y) - DiffW'(req_i.vertex_a_y);
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: squares, 2x2 minors and the orientation products
  // ---------------------------------------------------------------------
  logic signed [ProdW-1:0] sq_ax_q, sq_ay_q, sq_bx_q, sq_by_q, sq_cx_q, sq_cy_q;
  logic signed [ProdW-1:0] p_bc_q, p_cb_q, p_ca_q, p_ac_q, p_ab_q, p_ba_q;
  logic signed [ProdW-1:0] o1_q, o2_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_ax_q <= da_x_q * da_x_q;
      sq_ay_q <= da_y_q * da_y_q;
      sq_bx_q <= db_x_q * db_x_q;
      sq_by_q <= db_y_q * db_y_q;
      sq_cx_q <= dc_x_q * dc_x_q;
      sq_cy_q <= dc_y_q * dc_y_q;
      p_bc_q  <= db_x_q * dc_y_q;
      p_cb_q  <= dc_x_q * db_y_q;
      p_ca_q  <= dc_x_q * da_y_q;
      p_ac_q  <= da_x_q * dc_y_q;
      p_ab_q  <= da_x_q * db_y_q;
      p_ba_q  <= db_x_q * da_y_q;
      o1_q    <= e1_x_q * e2_y_q;
      o2_q    <= e1_y_q * e2_x_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 3: squared distances, cofactors and the orientation
  // ---------------------------------------------------------------------
  logic signed [NormW-1:0] norm_a_q, norm_b_q, norm_c_q;
  logic signed [NormW-1:0] cross_a_q, cross_b_q, cross_c_q;
  logic signed [NormW-1:0] orient_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      norm_a_q  <= NormW'(sq_ax_q) + NormW'(sq_ay_q);
      norm_b_q  <= NormW'(sq_bx_q) + NormW'(sq_by_q);
      norm_c_q  <= NormW'(sq_cx_q) + NormW'(sq_cy_q);
      cross_a_q <= NormW'(p_bc_q) - NormW'(p_cb_q);
      cross_b_q <= NormW'(p_ca_q) - NormW'(p_ac_q);
      cross_c_q <= NormW'(p_ab_q) - NormW'(p_ba_q);
      orient_q  <= NormW'(o1_q) - NormW'(o2_q);
    end
  end

  // ---------------------------------------------------------------------
  // stages 4 and 5: norm x cofactor, split into partial products
  // ---------------------------------------------------------------------
  ict_mul_en_t             mul_en;
  logic signed [TermW-1:0] term_a, term_b, term_c;

  assign mul_en.pp  = en[4];
  assign mul_en.sum = en[5];

  ict_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_a (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .norm_i  (norm_a_q),
    .cross_i (cross_a_q),
    .term_o  (term_a)
  );

  ict_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_b (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .norm_i  (norm_b_q),
    .cross_i (cross_b_q),
    .term_o  (term_b)
  );

  ict_term_mul #(.COORD_WIDTH(COORD_WIDTH)) u_mul_c (
    .clk_i   (clk_i),
    .en_i    (mul_en),
    .norm_i  (norm_c_q),
    .cross_i (cross_c_q),
    .term_o  (term_c)
  );

  // orientation sign travels beside the multiplier stages
  logic o_neg4_q, o_zero4_q, o_neg5_q, o_zero5_q, o_neg6_q, o_zero6_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      o_neg4_q  <= orient_q[NormW-1];
      o_zero4_q <= (orient_q == '0);
    end
    if (en[5]) begin
      o_neg5_q  <= o_neg4_q;
      o_zero5_q <= o_zero4_q;
    end
    if (en[6]) begin
      o_neg6_q  <= o_neg5_q;
      o_zero6_q <= o_zero5_q;
    end
  end

  // ---------------------------------------------------------------------
  // stage 6: determinant
  // ---------------------------------------------------------------------
  logic signed [DetW-1:0] det_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      det_q <= DetW'(term_a) + DetW'(term_b) + DetW'(term_c);
    end
  end

  // ---------------------------------------------------------------------
  // stage 7: classification into the output register
  // sign of det times sign of orientation: positive means inside
  // ---------------------------------------------------------------------
  relation_e rel_d;
  logic [1:0] rel_q;

  always_comb begin
    if (o_zero6_q) begin
      rel_d = REL_DEGENERATE;
    end else if (det_q == '0) begin
      rel_d = REL_ON;
    end else if (det_q[DetW-1] ^ o_neg6_q) begin
      rel_d = REL_OUTSIDE;
    end else begin
      rel_d = REL_INSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      rel_q <= rel_d;
    end
  end

  assign rsp_o.valid    = v_q[NumStages];
  assign rsp_o.relation = rel_q;

`ifndef NO_ASSERTIONS
  // an accepted request always occupies the first stage next cycle
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> v_q[1])
    else $error("accepted request missing from stage 1");

  // with the output register empty the whole pipeline must move
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_o.valid |-> req_i.ready)
    else $error("pipeline stalled with empty output register");

  // a collinear triangle always leaves as degenerate
  a_degenerate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en[7] && v_q[6] && o_zero6_q |=> rsp_o.relation == REL_DEGENERATE)
    else $error("collinear triangle not flagged degenerate");
`endif

endmodule

`default_nettype wire

[verif/incircle_checker.sv]
`timescale 1ns / 100ps
// incircle_checker: watches the request and result channels of incircle_test_core
// predicts each relation with exact wide arithmetic and compares in order
// depends on ict_pkg, ict_in_if and ict_out_if
module incircle_checker import ict_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ict_in_if          req_i,
  ict_out_if         rsp_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  // the determinant needs four coordinate widths plus eight bits of headroom
  typedef logic signed [4*COORD_WIDTH+7:0] wide_t;

  relation_e relation_q[$];
  relation_e expected;

  function automatic relation_e incircle_relation(
    input coord_t px, py, ax, ay, bx, by, cx, cy
  );
    wide_t wpx, wpy, wax, way, wbx, wby, wcx, wcy;
    wide_t orient, dax, day, dbx, dby, dcx, dcy, na, nb, nc, det;
    wpx = px; wpy = py; wax = ax; way = ay;
    wbx = bx; wby = by; wcx = cx; wcy = cy;
    orient = (wbx - wax) * (wcy - way) - (wby - way) * (wcx - wax);
    if (orient == 0) return REL_DEGENERATE;
    dax = wax - wpx; day = way - wpy;
    dbx = wbx - wpx; dby = wby - wpy;
    dcx = wcx - wpx; dcy = wcy - wpy;
    na = dax * dax + day * day;
    nb = dbx * dbx + dby * dby;
    nc = dcx * dcx + dcy * dcy;
    det = na * (dbx * dcy - dcx * dby)
        + nb * (dcx * day - dax * dcy)
        + nc * (dax * dby - dbx * day);
    if (det == 0) return REL_ON;
    // sign of the orientation undoes a clockwise vertex order
    return ((det > 0) == (orient > 0)) ? REL_INSIDE : REL_OUTSIDE;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relation_q.delete();
      pending_o = 0;
    end else begin
      // push before pop so a result in the same cycle as its request would still line up
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        relation_q.insert(relation_q.size(), incircle_relation(
          req_i.point_x, req_i.point_y, req_i.vertex_a_x, req_i.vertex_a_y,
          req_i.vertex_b_x, req_i.vertex_b_y, req_i.vertex_c_x, req_i.vertex_c_y));
      end
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (relation_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          $display("%0t: relation expected none got %0d", $time, rsp_i.relation);
        end else begin
          expected = relation_q.pop_front();
          if (rsp_i.relation !== expected) begin
            fail_count_o = fail_count_o + 1;
            $display("%0t: relation expected %0d (%s) got %0d",
                     $time, expected, expected.name(), rsp_i.relation);
          end
        end
      end
      pending_o = relation_q.size();
    end
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for incircle_test_core
// depends on ict_pkg, ict_if, incircle_test_core and incircle_checker
module tb_top;
  import ict_pkg::*;

  localparam int unsigned CW = COORD_WIDTH_DEF;
  localparam int COORD_MAX = (2 ** (CW - 1)) - 1;
  localparam int COORD_MIN = -(2 ** (CW - 1));
  localparam int ONE = 65536;                 // 1.0 in Q8.16
  localparam int RANDOM_PER_PHASE = 235;      // four phases, about 950 requests
  localparam int DRAIN_CYCLES = 20;           // pipeline is seven deep
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef logic signed [CW-1:0] coord_t;
  // point x/y, then vertices a, b and c as x/y pairs
  typedef int quad_t [8];

  logic clk_i;
  logic rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int idle_pct;
  int stall_pct;

  ict_in_if  #(.COORD_WIDTH(CW)) req_if ();
  ict_out_if                     rsp_if ();

  incircle_test_core #(.COORD_WIDTH(CW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  incircle_checker #(.COORD_WIDTH(CW)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: far beyond the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("incircle_test_core: mismatch");
      $finish;
    end
  end

  // result side back-pressure, redrawn every cycle at the falling edge
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // one request: optional idle gap, then hold it until the core takes it
  task automatic send_request(input int px, py, ax, ay, bx, by, cx, cy);
    while ($urandom_range(0, 99) < idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.point_x    = coord_t'(px);
    req_if.point_y    = coord_t'(py);
    req_if.vertex_a_x = coord_t'(ax);
    req_if.vertex_a_y = coord_t'(ay);
    req_if.vertex_b_x = coord_t'(bx);
    req_if.vertex_b_y = coord_t'(by);
    req_if.vertex_c_x = coord_t'(cx);
    req_if.vertex_c_y = coord_t'(cy);
    @(posedge clk_i);
    while (req_if.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_quad(input quad_t q);
    send_request(q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7]);
  endtask

  // sender holds off until every predicted relation has come back
  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // full-range coordinate with a bias towards the ends of the range and towards zero
  function automatic int any_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom);
    endcase
  endfunction

  // four points on one circle, radius 5 scaled, so the exact on-circle case
  // comes up often; nudged by one lsb it probes the sign right beside zero
  function automatic quad_t cocircular(input bit nudge);
    quad_t q;
    int rx [12] = '{5, -5, 0, 0, 3, 3, -3, -3, 4, 4, -4, -4};
    int ry [12] = '{0, 0, 5, -5, 4, -4, 4, -4, 3, -3, 3, -3};
    int idx [4];
    int s, lim, ox, oy, v;
    bit dup;
    s = $urandom_range(0, 1) ? int'($urandom_range(1, 16))
                             : int'($urandom_range(1, 1677000));
    lim = COORD_MAX - 5 * s;
    ox = int'($urandom_range(0, 2 * lim)) - lim;
    oy = int'($urandom_range(0, 2 * lim)) - lim;
    for (int k = 0; k < 4; k++) begin
      do begin
        idx[k] = $urandom_range(0, 11);
        dup = 1'b0;
        for (int j = 0; j < k; j++) if (idx[j] == idx[k]) dup = 1'b1;
      end while (dup);
      q[2 * k]     = ox + s * rx[idx[k]];
      q[2 * k + 1] = oy + s * ry[idx[k]];
    end
    // query point sitting exactly on a vertex
    if ($urandom_range(0, 6) == 0) begin
      v = $urandom_range(1, 3);
      q[0] = q[2 * v];
      q[1] = q[2 * v + 1];
    end
    if (nudge) begin
      if ($urandom_range(0, 1)) q[0] = q[0] + ($urandom_range(0, 1) ? 1 : -1);
      else                      q[1] = q[1] + ($urandom_range(0, 1) ? 1 : -1);
    end
    return q;
  endfunction

  // vertices on one line, coincident when the step is zero
  function automatic quad_t collinear();
    quad_t q;
    int bx0, by0, dx, dy, k;
    bx0 = int'($urandom_range(0, 8000000)) - 4000000;
    by0 = int'($urandom_range(0, 8000000)) - 4000000;
    dx  = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 2000)) - 1000;
    dy  = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, 2000)) - 1000;
    q[0] = any_coord();
    q[1] = any_coord();
    for (int v = 1; v < 4; v++) begin
      k = int'($urandom_range(0, 2000)) - 1000;
      q[2 * v]     = bx0 + k * dx;
      q[2 * v + 1] = by0 + k * dy;
    end
    return q;
  endfunction

  function automatic quad_t random_item();
    quad_t q;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      // tiny grid: plenty of collinear and cocircular accidents
      for (int i = 0; i < 8; i++) q[i] = int'($urandom_range(0, 12)) - 6;
    end else if (pick < 25) begin
      q = collinear();
    end else if (pick < 50) begin
      q = cocircular(1'b0);
    end else if (pick < 65) begin
      q = cocircular(1'b1);
    end else begin
      for (int i = 0; i < 8; i++) q[i] = any_coord();
    end
    return q;
  endfunction

  // hand-picked corners of the behaviour, both vertex orders where it matters
  task automatic run_directed();
    // all at one extreme: coincident vertices
    send_request(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                 COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    send_request(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN,
                 COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    // full-range rectangle corners lie on one circle, ccw then cw
    send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                 COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    send_request(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
                 COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    // full-range triangle with the origin inside, and the far corner outside
    send_request(0, 0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, 0, COORD_MAX);
    send_request(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN,
                 COORD_MAX, COORD_MIN, 0, COORD_MAX);
    // unit triangle: inside, outside, on a vertex; each in both orders
    send_request(ONE / 4, ONE / 4, 0, 0, ONE, 0, 0, ONE);
    send_request(ONE / 4, ONE / 4, 0, 0, 0, ONE, ONE, 0);
    send_request(3 * ONE, 3 * ONE, 0, 0, ONE, 0, 0, ONE);
    send_request(3 * ONE, 3 * ONE, 0, 0, 0, ONE, ONE, 0);
    send_request(0, 0, 0, 0, ONE, 0, 0, ONE);
    send_request(0, ONE, 0, 0, 0, ONE, ONE, 0);
    // lsb-sized triangle: fourth square corner on, next one out
    send_request(1, 1, 0, 0, 1, 0, 0, 1);
    send_request(2, 2, 0, 0, 1, 0, 0, 1);
    send_request(-1, -1, 0, 0, 1, 0, 0, 1);
    // collinear, fully coincident, and two vertices coincident
    send_request(ONE, 0, -ONE, -ONE, 0, 0, ONE, ONE);
    send_request(5, 7, 3, 3, 3, 3, 3, 3);
    send_request(5, 7, 3, 3, 3, 3, 9, -2);
    // collinear along the extreme rows and columns
    send_request(0, 0, COORD_MIN, COORD_MAX, 0, COORD_MAX, COORD_MAX, COORD_MAX);
    send_request(0, 0, COORD_MIN, COORD_MIN, COORD_MIN, 0, COORD_MIN, COORD_MAX);
    // query far away from a small triangle
    send_request(COORD_MIN, COORD_MAX, 0, 0, ONE, 0, 0, ONE);
  endtask

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    phase_idle        = '{0, 46, 0, 9};
    phase_stall       = '{0, 0, 46, 9};
    idle_pct          = 0;
    stall_pct         = 0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.point_x    = '0;
    req_if.point_y    = '0;
    req_if.vertex_a_x = '0;
    req_if.vertex_a_y = '0;
    req_if.vertex_b_x = '0;
    req_if.vertex_b_y = '0;
    req_if.vertex_c_x = '0;
    req_if.vertex_c_y = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int p = 0; p < 4; p++) begin
      // each phase starts from an empty pipeline, so the sender also
      // sits out a full drain at least once
      wait_drained();
      idle_pct  = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) run_directed();
      repeat (RANDOM_PER_PHASE) send_quad(random_item());
    end

    wait_drained();
    // let any stray result surface before the verdict
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("incircle_test_core: match");
    end else begin
      $display("incircle_test_core: mismatch");
    end
    $finish;
  end

endmodule
